[hdl/btc_pkg.sv]
// ----------------------------------------------------------------------------
// btc_pkg: shared types and constants for barometer trim compensation
// Field widths, status codes, register indexes, clamp limits and the
// sideband record that travels with an item through the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btc_pkg;

   // field widths
   localparam int RAW_W   = 20;
   localparam int TEMP_W  = 15;
   localparam int PRESS_W = 25;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 64;
   localparam int IDX_W   = 2;

   // divider geometry
   localparam int NUM_W   = 69;
   localparam int DEN_W   = 31;
   localparam int QUO_W   = 37;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STAT_W-1:0] STAT_TEMP_CLAMP  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ZERO_DIV    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_PRESS_CLAMP = 2'd3;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_TEMP_TRIM  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_PRESS_LOW  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_PRESS_HIGH = 2'd2;
   localparam logic [IDX_W-1:0] CSR_PRESS_LAST = 2'd3;

   // limits and fixed-point constants
   localparam logic signed [TEMP_W-1:0] TEMP_LO   = -15'sd4000;
   localparam logic signed [TEMP_W-1:0] TEMP_HI   = 15'sd8500;
   localparam logic [PRESS_W-1:0]       PRESS_LO  = 25'd7680000;
   localparam logic [PRESS_W-1:0]       PRESS_HI  = 25'd28160000;
   localparam logic signed [23:0]       TFINE_OFS = 24'sd128000;
   localparam logic [11:0]              SCALE_Q   = 12'd3125;

   // sideband carried alongside the pressure datapath
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic                     tclamp;
      logic                     zden;
      logic                     neg;
   } side_type;

endpackage

`default_nettype wire

[hdl/barometer_trim_compensation.sv]
// Throughput: one item per cycle; all stages advance together and hold while the skid register is occupied.
// The divider, an entry stage and 37 step stages with one quotient bit per step, sets most of the depth.
// A skid register behind the output keeps req_tready off rsp_tready.
// Reset clears all trim registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// barometer_trim_compensation: barometric sensor trim compensation
// Fixed-point temperature and pressure trim polynomials, with clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module barometer_trim_compensation import btc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   // configuration
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   // raw samples
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [39:0]      req_tdata,   // raw_temp[19:0], raw_press[39:20]
   // results
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [39:0]           rsp_tdata,   // temp_centi[14:0], press_q8[39:15]
   output logic [STAT_W-1:0]     rsp_tuser    // result_status[1:0]
);

   // trim registers
   logic [47:0] temp_trim_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff  <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_last_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEMP_TRIM:  temp_trim_ff  <= csr_wdata[47:0];
            CSR_PRESS_LOW:  press_low_ff  <= csr_wdata;
            CSR_PRESS_HIGH: press_high_ff <= csr_wdata;
            CSR_PRESS_LAST: press_last_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic        [15:0] tr_t1, tr_p1;
   logic signed [15:0] tr_t2, tr_t3, tr_p2, tr_p3, tr_p4, tr_p5;
   logic signed [15:0] tr_p6, tr_p7, tr_p8, tr_p9;

   assign tr_t1 = temp_trim_ff[15:0];
   assign tr_t2 = temp_trim_ff[31:16];
   assign tr_t3 = temp_trim_ff[47:32];
   assign tr_p1 = press_low_ff[15:0];
   assign tr_p2 = press_low_ff[31:16];
   assign tr_p3 = press_low_ff[47:32];
   assign tr_p4 = press_low_ff[63:48];
   assign tr_p5 = press_high_ff[15:0];
   assign tr_p6 = press_high_ff[31:16];
   assign tr_p7 = press_high_ff[47:32];
   assign tr_p8 = press_high_ff[63:48];
   assign tr_p9 = press_last_ff;

   // pipeline advance, held while the skid register is occupied
   logic pipe_ready;
   logic skid_v_ff;
   assign pipe_ready = !skid_v_ff;
   assign req_tready = pipe_ready;

   logic [RAW_W-1:0] raw_temp, raw_press;
   assign raw_temp  = req_tdata[19:0];
   assign raw_press = req_tdata[39:20];

   // valid bits of stages one to nine and of the four stages after the divider
   logic [8:0] s_v_ff;
   logic [3:0] post_v_ff;
   logic       div_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff    <= '0;
         post_v_ff <= '0;
      end else if (pipe_ready) begin
         s_v_ff    <= {s_v_ff[7:0], req_tvalid};
         post_v_ff <= {post_v_ff[2:0], div_valid};
      end
   end

   // raw pressure rides along until the numerator stage
   logic [RAW_W-1:0] rp_ff [0:6];

   always_ff @(posedge clock) begin
      if (pipe_ready) begin
         rp_ff[0] <= raw_press;
         for (int i = 1; i < 7; i++) rp_ff[i] <= rp_ff[i-1];
      end
   end

   // stage 1: linear and quadratic temperature products
   logic signed [17:0] s1_diff;
   logic signed [16:0] s1_d;
   logic signed [33:0] s1_aprod_in, s1_aprod_ff, s1_ddfull;
   logic        [31:0] s1_dd_in, s1_dd_ff;

   assign s1_diff     = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, tr_t1, 1'b0});
   assign s1_d        = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, tr_t1});
   assign s1_aprod_in = 34'(s1_diff) * 34'(tr_t2);
   assign s1_ddfull   = 34'(s1_d) * 34'(s1_d);
   assign s1_dd_in    = s1_ddfull[31:0];

   // stage 2: scale linear term, quadratic term times t3
   logic signed [22:0] s2_a_in, s2_a_ff;
   logic signed [36:0] s2_bprod_in, s2_bprod_ff;

   assign s2_a_in     = s1_aprod_ff[33:11];
   assign s2_bprod_in = 37'($signed({1'b0, s1_dd_ff[31:12]})) * 37'(tr_t3);

   // stage 3: fine temperature
   logic signed [22:0] s3_b;
   logic signed [23:0] s3_tfine_in, s3_tfine_ff;

   assign s3_b        = s2_bprod_ff[36:14];
   assign s3_tfine_in = 24'(s2_a_ff) + 24'(s3_b);

   // stage 4: temperature in 0.01 C with clamp, pressure offset
   logic signed [26:0] s4_tsum;
   logic signed [18:0] s4_traw;
   logic signed [19:0] s4_w_in, s4_w_ff;
   logic signed [23:0] s4_wfull;
   side_type           s4_side_in, s4_side_ff;

   assign s4_tsum  = (27'(s3_tfine_ff) <<< 2) + 27'(s3_tfine_ff) + 27'sd128;
   assign s4_traw  = s4_tsum[26:8];
   assign s4_wfull = s3_tfine_ff - TFINE_OFS;
   assign s4_w_in  = s4_wfull[19:0];

   always_comb begin
      s4_side_in        = '0;
      s4_side_in.temp   = s4_traw[TEMP_W-1:0];
      if (s4_traw < 19'(TEMP_LO)) begin
         s4_side_in.temp   = TEMP_LO;
         s4_side_in.tclamp = 1'b1;
      end else if (s4_traw > 19'(TEMP_HI)) begin
         s4_side_in.temp   = TEMP_HI;
         s4_side_in.tclamp = 1'b1;
      end
   end

   // stage 5: offset squared and linear pressure products
   logic signed [39:0] s5_wwfull;
   logic signed [38:0] s5_ww_in, s5_ww_ff;
   logic signed [35:0] s5_wp5_in, s5_wp5_ff, s5_wp2_in, s5_wp2_ff;
   side_type           s5_side_ff;

   assign s5_wwfull = 40'(s4_w_ff) * 40'(s4_w_ff);
   assign s5_ww_in  = s5_wwfull[38:0];
   assign s5_wp5_in = 36'(s4_w_ff) * 36'(tr_p5);
   assign s5_wp2_in = 36'(s4_w_ff) * 36'(tr_p2);

   // stage 6: quadratic pressure products
   logic signed [54:0] s6_ea_in, s6_ea_ff, s6_fa_in, s6_fa_ff;
   logic signed [35:0] s6_wp5_ff, s6_wp2_ff;
   side_type           s6_side_ff;

   assign s6_ea_in = 55'(s5_ww_ff) * 55'(tr_p6);
   assign s6_fa_in = 55'(s5_ww_ff) * 55'(tr_p3);

   // stage 7: offset term and divisor sum
   logic signed [46:0] s7_fsh;
   logic signed [49:0] s7_f;
   logic signed [56:0] s7_e_in, s7_e_ff;
   logic signed [50:0] s7_s_in, s7_s_ff;
   side_type           s7_side_ff;

   assign s7_fsh  = s6_fa_ff[54:8];
   assign s7_e_in = 57'(s6_ea_ff) + (57'(s6_wp5_ff) <<< 17) + (57'(tr_p4) <<< 35);
   assign s7_f    = 50'(s7_fsh) + (50'(s6_wp2_ff) <<< 12);
   assign s7_s_in = 51'(s7_f) + (51'sd1 <<< 47);

   // stage 8: divisor and numerator magnitude
   logic signed [67:0] s8_dprod;
   logic        [20:0] s8_inv;
   logic signed [57:0] s8_x;
   logic        [57:0] s8_xabs;
   logic [DEN_W-1:0]   s8_den_in, s8_den_ff;
   logic        [56:0] s8_mag_ff;
   side_type           s8_side_in, s8_side_ff;

   assign s8_dprod  = 68'(s7_s_ff) * 68'($signed({1'b0, tr_p1}));
   assign s8_den_in = s8_dprod[63:33];
   assign s8_inv    = 21'h100000 - {1'b0, rp_ff[6]};
   assign s8_x      = (58'($signed({1'b0, s8_inv})) <<< 31) - 58'(s7_e_ff);
   assign s8_xabs   = s8_x[57] ? 58'(-s8_x) : s8_x;

   always_comb begin
      s8_side_in      = s7_side_ff;
      s8_side_in.zden = (s8_den_in == '0);
      s8_side_in.neg  = s8_x[57];
   end

   // stage 9: scaled numerator
   logic [NUM_W-1:0] s9_num_in, s9_num_ff;
   logic [DEN_W-1:0] s9_den_ff;
   side_type         s9_side_ff;

   assign s9_num_in = 69'(s8_mag_ff) * 69'(SCALE_Q);

   always_ff @(posedge clock) begin
      if (pipe_ready) begin
         s1_aprod_ff <= s1_aprod_in;
         s1_dd_ff    <= s1_dd_in;
         s2_a_ff     <= s2_a_in;
         s2_bprod_ff <= s2_bprod_in;
         s3_tfine_ff <= s3_tfine_in;
         s4_w_ff     <= s4_w_in;
         s4_side_ff  <= s4_side_in;
         s5_ww_ff    <= s5_ww_in;
         s5_wp5_ff   <= s5_wp5_in;
         s5_wp2_ff   <= s5_wp2_in;
         s5_side_ff  <= s4_side_ff;
         s6_ea_ff    <= s6_ea_in;
         s6_fa_ff    <= s6_fa_in;
         s6_wp5_ff   <= s5_wp5_ff;
         s6_wp2_ff   <= s5_wp2_ff;
         s6_side_ff  <= s5_side_ff;
         s7_e_ff     <= s7_e_in;
         s7_s_ff     <= s7_s_in;
         s7_side_ff  <= s6_side_ff;
         s8_den_ff   <= s8_den_in;
         s8_mag_ff   <= s8_xabs[56:0];
         s8_side_ff  <= s8_side_in;
         s9_num_ff   <= s9_num_in;
         s9_den_ff   <= s8_den_ff;
         s9_side_ff  <= s8_side_ff;
      end
   end

   // quotient pipeline
   logic [QUO_W-1:0] div_quo;
   logic             div_ovf;
   side_type         div_side;

   btc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_ready),
      .in_valid  (s_v_ff[8]),
      .in_num    (s9_num_ff),
      .in_den    (s9_den_ff),
      .in_side   (s9_side_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_ovf   (div_ovf),
      .out_side  (div_side)
   );

   // saturate and sign the quotient
   logic [QUO_W-1:0]   sq_mag;
   logic signed [37:0] sq_q_in, sq_q_ff;
   side_type           sq_side_ff;

   assign sq_mag  = (div_ovf || div_quo[QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}} : div_quo;
   assign sq_q_in = div_side.neg ? -$signed({1'b0, sq_mag}) : $signed({1'b0, sq_mag});

   // square of the coarse quotient and the p8 product
   logic signed [24:0] ps1_g0;
   logic signed [49:0] ps1_gfull;
   logic signed [47:0] ps1_gsq_in, ps1_gsq_ff;
   logic signed [53:0] ps1_hp_in, ps1_hp_ff;
   logic signed [37:0] ps1_q_ff;
   side_type           ps1_side_ff;

   assign ps1_g0     = sq_q_ff[37:13];
   assign ps1_gfull  = 50'(ps1_g0) * 50'(ps1_g0);
   assign ps1_gsq_in = ps1_gfull[47:0];
   assign ps1_hp_in  = 54'(sq_q_ff) * 54'(tr_p8);

   // p9 times the squared term
   logic signed [63:0] ps2_gp_in, ps2_gp_ff;
   logic signed [53:0] ps2_hp_ff;
   logic signed [37:0] ps2_q_ff;
   side_type           ps2_side_ff;

   assign ps2_gp_in = 64'(ps1_gsq_ff) * 64'(tr_p9);

   // final sum and p7 offset
   logic signed [38:0] ps3_g;
   logic signed [34:0] ps3_h;
   logic signed [40:0] ps3_sum;
   logic signed [32:0] ps3_sumsh;
   logic signed [33:0] ps3_press_in, ps3_press_ff;
   side_type           ps3_side_ff;

   assign ps3_g        = ps2_gp_ff[63:25];
   assign ps3_h        = ps2_hp_ff[53:19];
   assign ps3_sum      = 41'(ps2_q_ff) + 41'(ps3_g) + 41'(ps3_h);
   assign ps3_sumsh    = ps3_sum[40:8];
   assign ps3_press_in = 34'(ps3_sumsh) + (34'(tr_p7) <<< 4);

   always_ff @(posedge clock) begin
      if (pipe_ready) begin
         sq_q_ff      <= sq_q_in;
         sq_side_ff   <= div_side;
         ps1_gsq_ff   <= ps1_gsq_in;
         ps1_hp_ff    <= ps1_hp_in;
         ps1_q_ff     <= sq_q_ff;
         ps1_side_ff  <= sq_side_ff;
         ps2_gp_ff    <= ps2_gp_in;
         ps2_hp_ff    <= ps1_hp_ff;
         ps2_q_ff     <= ps1_q_ff;
         ps2_side_ff  <= ps1_side_ff;
         ps3_press_ff <= ps3_press_in;
         ps3_side_ff  <= ps2_side_ff;
      end
   end

   // result formatting with clamps and status
   logic [PRESS_W-1:0] res_press;
   logic [STAT_W-1:0]  res_stat;

   always_comb begin
      res_press = '0;
      res_stat  = STAT_OK;
      if (ps3_side_ff.tclamp) begin
         res_stat = STAT_TEMP_CLAMP;
      end else if (ps3_side_ff.zden) begin
         res_stat = STAT_ZERO_DIV;
      end else if (ps3_press_ff < $signed({9'b0, PRESS_LO})) begin
         res_press = PRESS_LO;
         res_stat  = STAT_PRESS_CLAMP;
      end else if (ps3_press_ff > $signed({9'b0, PRESS_HI})) begin
         res_press = PRESS_HI;
         res_stat  = STAT_PRESS_CLAMP;
      end else begin
         res_press = ps3_press_ff[PRESS_W-1:0];
      end
   end

   // output register with skid stage
   logic              pipe_fire;
   logic              out_v_ff;
   logic [39:0]       out_data_ff, skid_data_ff;
   logic [STAT_W-1:0] out_user_ff, skid_user_ff;

   assign pipe_fire = post_v_ff[3] && pipe_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff  <= skid_v_ff || pipe_fire;
         skid_v_ff <= 1'b0;
      end else if (pipe_fire) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_data_ff <= skid_v_ff ? skid_data_ff : {res_press, ps3_side_ff.temp};
         out_user_ff <= skid_v_ff ? skid_user_ff : res_stat;
      end else if (pipe_fire) begin
         skid_data_ff <= {res_press, ps3_side_ff.temp};
         skid_user_ff <= res_stat;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

[hdl/btc_div.sv]
// ----------------------------------------------------------------------------
// btc_div: pipelined restoring divider
// One quotient bit per stage; flags quotients of 2^37 and above as overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btc_div import btc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [NUM_W-1:0]   in_num,
   input  wire logic [DEN_W-1:0]   in_den,
   input  wire side_type           in_side,
   output logic                    out_valid,
   output logic [QUO_W-1:0]        out_quo,
   output logic                    out_ovf,
   output side_type                out_side
);

   logic [DEN_W-1:0] rem_ff  [0:QUO_W];
   logic [QUO_W-1:0] bits_ff [0:QUO_W];
   logic [DEN_W-1:0] den_ff  [0:QUO_W];
   logic             ovf_ff  [0:QUO_W];
   side_type         side_ff [0:QUO_W];
   logic             valid_ff[0:QUO_W];

   // entry stage: split dividend, check that the quotient fits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_num[NUM_W-2:QUO_W];
         bits_ff[0] <= in_num[QUO_W-1:0];
         ovf_ff[0]  <= (in_num[NUM_W-1:QUO_W] >= {1'b0, in_den});
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   // one quotient bit per stage
   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           fit;

      always_comb begin
         trial = {rem_ff[i], bits_ff[i][QUO_W-1]};
         diff  = trial - {1'b0, den_ff[i]};
         fit   = (trial >= {1'b0, den_ff[i]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1]  <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            bits_ff[i+1] <= {bits_ff[i][QUO_W-2:0], fit};
            den_ff[i+1]  <= den_ff[i];
            ovf_ff[i+1]  <= ovf_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = bits_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

`default_nettype wire

[hdl/btc_check.sv]
// ----------------------------------------------------------------------------
// btc_check: port-level checks for barometer trim compensation
// Watches the result channel for held payloads and consistent status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btc_check import btc_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [39:0]       rsp_tdata,
   input wire logic [STAT_W-1:0] rsp_tuser
);

   logic signed [TEMP_W-1:0] temp;
   logic [PRESS_W-1:0]       press;
   assign temp  = rsp_tdata[14:0];
   assign press = rsp_tdata[39:15];

   // stalled result transfer holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // clamped temperature sits on a limit and carries no pressure
   a_tclamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_TEMP_CLAMP |->
         press == '0 && (temp == TEMP_LO || temp == TEMP_HI))
      else $error("bad temperature clamp result");

   // zero divisor gives zero pressure and an in-range temperature
   a_zden: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_ZERO_DIV |->
         press == '0 && temp >= TEMP_LO && temp <= TEMP_HI)
      else $error("bad zero divisor result");

   // clamped pressure sits on a limit
   a_pclamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_PRESS_CLAMP |->
         press == PRESS_LO || press == PRESS_HI)
      else $error("bad pressure clamp result");

   // good result lies inside both ranges
   a_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_OK |->
         press >= PRESS_LO && press <= PRESS_HI && temp >= TEMP_LO && temp <= TEMP_HI)
      else $error("result out of range");

endmodule

bind barometer_trim_compensation btc_check u_btc_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
